// ===== sv/frcf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the fixed-record circular FIFO.
// No dependencies; every other file of the block but frcf_ram imports this package.
package frcf_pkg;

    // Sizing of the ring and of one record
    localparam int MAX_SLOTS        = 16;
    localparam int MAX_RECORD_BYTES = 64;
    localparam int STORE_DEPTH      = MAX_SLOTS * MAX_RECORD_BYTES;

    localparam int SLOT_W   = $clog2(MAX_SLOTS);
    localparam int SCNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int POS_W    = $clog2(MAX_RECORD_BYTES);
    localparam int RB_W     = $clog2(MAX_RECORD_BYTES + 1);
    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int BASE_W   = SLOT_W + RB_W;
    localparam int OP_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_BYTES = CFG_IDX_W'(1);

    localparam logic [SCNT_W-1:0] SLOTS_RESET = SCNT_W'(16);
    localparam logic [RB_W-1:0]   BYTES_RESET = RB_W'(4);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_DROP  = 3'd3,
        OP_FLUSH = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_STREAM = 1'b1
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic exec;       // carry out the accepted operation
        logic emit_byte;  // move the read byte into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_valid;    // output register holds a word
        logic starts_read;  // offered op is a pop or peek on a non-empty FIFO
        logic last_pos;     // the byte being streamed is the last of its record
    } t_dp_stat;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                last_byte;
        logic [STATUS_W-1:0] status;
        logic [SCNT_W-1:0]   used_slots;
        logic [SCNT_W-1:0]   free_slots;
        logic                is_full;
        logic                is_empty;
    } t_result;

endpackage

// ===== sv/frcf_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the fixed-record circular FIFO:
// operation words in, result words out, configuration writes. Uses frcf_pkg.
interface frcf_in_if import frcf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface frcf_out_if import frcf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic                last_byte;
    logic [STATUS_W-1:0] status;
    logic [SCNT_W-1:0]   used_slots;
    logic [SCNT_W-1:0]   free_slots;
    logic                is_full;
    logic                is_empty;

    modport source (output valid, output out_byte, output last_byte, output status,
                    output used_slots, output free_slots, output is_full,
                    output is_empty, input ready);
    modport sink   (input valid, input out_byte, input last_byte, input status,
                    input used_slots, input free_slots, input is_full,
                    input is_empty, output ready);
endinterface

interface frcf_cfg_if import frcf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/fixed_record_circular_fifo.sv =====
`timescale 1ns / 1ps
// Top level of the fixed-record circular FIFO: controller plus datapath.
// Uses frcf_pkg, frcf_ifs, frcf_ctrl, frcf_datapath.

// A ring of up to 16 records of 1 to 64 bytes, built byte by byte with push
// and read back with pop or peek. Push, drop, flush, reserved and rejected
// operations may follow each other every cycle while the output register
// is free; their single result word is loaded into it on acceptance. A pop
// or peek of a held record gives record_bytes words, one per cycle once the
// first is out and while the receiver takes them; the first byte passes the
// registered read of the record store before the output register, and the
// next operation word is taken only after the last byte is loaded, so no
// new operation enters while a record streams out. The store needs no
// clearing after reset. Configuration writes are always ready and flush the
// ring on a defined index; issue them only while the block is idle.
module fixed_record_circular_fifo import frcf_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    frcf_in_if.sink    i_in,
    frcf_out_if.source o_out,
    frcf_cfg_if.sink   i_cfg
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_result  w_result;
    logic     w_out_valid;
    logic     w_in_ready;

    frcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    frcf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_op        (i_in.op),
        .i_data_byte (i_in.data_byte),
        .i_cfg_wr    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_result    (w_result)
    );

    // Drive the channels
    assign i_in.ready       = w_in_ready;
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = w_out_valid;
    assign o_out.out_byte   = w_result.out_byte;
    assign o_out.last_byte  = w_result.last_byte;
    assign o_out.status     = w_result.status;
    assign o_out.used_slots = w_result.used_slots;
    assign o_out.free_slots = w_result.free_slots;
    assign o_out.is_full    = w_result.is_full;
    assign o_out.is_empty   = w_result.is_empty;

`ifndef SYNTHESIS
    // A read start blocks the input for the following cycle
    a_stream_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && w_stat.starts_read) |=> !i_in.ready)
        else $error("input taken right after a record read started");

    // No word is taken while a record streams out
    a_no_accept_in_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_byte |-> !i_in.ready)
        else $error("input ready during record stream");

    // Empty flag and used count agree
    a_empty_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_empty) |-> (o_out.used_slots == '0))
        else $error("empty word reports used slots");

    // Full flag and free count agree
    a_full_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_full) |-> (o_out.free_slots == '0))
        else $error("full word reports free slots");
`endif

endmodule

// ===== sv/frcf_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with
// registered read data held while the read enable is low. No dependencies.
module frcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/frcf_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the fixed-record circular FIFO: configuration registers,
// ring pointers, record store and output register. Uses frcf_pkg, frcf_ram.
module frcf_datapath import frcf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [OP_W-1:0]       i_op,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_result               o_result
);

    // Control state
    logic [SCNT_W-1:0] r_slots, n_slots;
    logic [RB_W-1:0]   r_bytes, n_bytes;
    logic [SLOT_W-1:0] r_head,  n_head;
    logic [SLOT_W-1:0] r_tail,  n_tail;
    logic              r_full,  n_full;
    logic [POS_W-1:0]  r_cnt,   n_cnt;
    logic              r_out_valid;

    // Stream payload state
    logic [SLOT_W-1:0] r_src;
    logic [POS_W-1:0]  r_pos;
    t_result           r_result;

    logic              fifo_empty;
    logic [POS_W-1:0]  cnt_eff;
    logic [RB_W-1:0]   cnt_inc;
    logic [SLOT_W-1:0] head_next;
    logic [SLOT_W-1:0] tail_next;
    logic              last_pos;
    logic              wr_en;
    logic              rd_en;
    logic [POS_W-1:0]  rd_pos;
    logic [SLOT_W-1:0] rd_slot;
    logic [BASE_W-1:0] wr_base;
    logic [BASE_W-1:0] rd_base;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] ram_rdata;
    logic              load_simple;
    logic              load_byte;
    t_status           res_status;
    logic [SCNT_W-1:0] used;
    t_result           res;
    logic [CFG_DATA_W-1:0] cfg_val;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                    input logic [SCNT_W-1:0] slots);
        logic [SCNT_W-1:0] n;
        n = SCNT_W'(s) + SCNT_W'(1);
        return (n >= slots) ? '0 : n[SLOT_W-1:0];
    endfunction

    function automatic logic [SCNT_W-1:0] used_count(input logic [SLOT_W-1:0] head,
                                                     input logic [SLOT_W-1:0] tail,
                                                     input logic              full,
                                                     input logic [SCNT_W-1:0] slots);
        logic [SCNT_W-1:0] u;
        if (full) begin
            u = slots;
        end else if (head >= tail) begin
            u = SCNT_W'(head) - SCNT_W'(tail);
        end else begin
            u = slots - (SCNT_W'(tail) - SCNT_W'(head));
        end
        return u;
    endfunction

    assign fifo_empty = !r_full && (r_head == r_tail);
    assign cnt_eff    = (RB_W'(r_cnt) >= r_bytes) ? '0 : r_cnt;
    assign cnt_inc    = RB_W'(cnt_eff) + RB_W'(1);
    assign head_next  = next_slot(r_head, r_slots);
    assign tail_next  = next_slot(r_tail, r_slots);
    assign last_pos   = (RB_W'(r_pos) == (r_bytes - RB_W'(1)));
    assign cfg_val    = i_cfg_data;

    // Operation decode and next state
    always_comb begin
        n_slots     = r_slots;
        n_bytes     = r_bytes;
        n_head      = r_head;
        n_tail      = r_tail;
        n_full      = r_full;
        n_cnt       = r_cnt;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_pos      = '0;
        load_simple = 1'b0;
        load_byte   = 1'b0;
        res_status  = ST_OK;

        if (i_cmd.exec) begin
            load_simple = !o_stat.starts_read;
            unique case (t_op'(i_op)) inside
                OP_PUSH: begin
                    if (r_full) begin
                        res_status = ST_FULL;
                    end else begin
                        wr_en = 1'b1;
                        // commit the record on its last byte
                        if (cnt_inc >= r_bytes) begin
                            n_cnt  = '0;
                            n_head = head_next;
                            n_full = (head_next == r_tail);
                        end else begin
                            n_cnt = cnt_inc[POS_W-1:0];
                        end
                    end
                end
                OP_POP, OP_PEEK: begin
                    if (fifo_empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        rd_en = 1'b1;
                        if (t_op'(i_op) == OP_POP) begin
                            n_tail = tail_next;
                            n_full = 1'b0;
                        end
                    end
                end
                OP_DROP: begin
                    if (fifo_empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        n_tail = tail_next;
                        n_full = 1'b0;
                    end
                end
                OP_FLUSH: begin
                    n_head = '0;
                    n_tail = '0;
                    n_full = 1'b0;
                    n_cnt  = '0;
                end
                default: begin
                end
            endcase
        end

        // Advance the stream: hand over this byte, fetch the next one unless it was the last
        if (i_cmd.emit_byte) begin
            load_byte = 1'b1;
            if (!last_pos) begin
                rd_en  = 1'b1;
                rd_pos = r_pos + POS_W'(1);
            end
        end

        // Write to a defined register clamps the register-width field into range and flushes the ring
        if (i_cfg_wr) begin
            if (i_cfg_index == CFG_SLOTS_IN_USE) begin
                if (cfg_val[SCNT_W-1:0] == '0) begin
                    n_slots = SCNT_W'(1);
                end else if (cfg_val[SCNT_W-1:0] > SCNT_W'(MAX_SLOTS)) begin
                    n_slots = SCNT_W'(MAX_SLOTS);
                end else begin
                    n_slots = cfg_val[SCNT_W-1:0];
                end
            end else if (i_cfg_index == CFG_RECORD_BYTES) begin
                if (cfg_val[RB_W-1:0] == '0) begin
                    n_bytes = RB_W'(1);
                end else if (cfg_val[RB_W-1:0] > RB_W'(MAX_RECORD_BYTES)) begin
                    n_bytes = RB_W'(MAX_RECORD_BYTES);
                end else begin
                    n_bytes = cfg_val[RB_W-1:0];
                end
            end
            if (i_cfg_index == CFG_SLOTS_IN_USE || i_cfg_index == CFG_RECORD_BYTES) begin
                n_head = '0;
                n_tail = '0;
                n_full = 1'b0;
                n_cnt  = '0;
            end
        end
    end

    // Store addressing: slot * record length + byte position
    assign rd_slot = i_cmd.exec ? r_tail : r_src;
    assign wr_base = BASE_W'(r_head) * BASE_W'(r_bytes);
    assign rd_base = BASE_W'(rd_slot) * BASE_W'(r_bytes);
    assign wr_addr = ADDR_W'(wr_base + BASE_W'(cnt_eff));
    assign rd_addr = ADDR_W'(rd_base + BASE_W'(rd_pos));

    frcf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_data_byte),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Result word, counts taken after this operation
    always_comb begin
        used           = used_count(n_head, n_tail, n_full, r_slots);
        res.out_byte   = load_byte ? ram_rdata : '0;
        res.last_byte  = load_byte ? last_pos : 1'b1;
        res.status     = load_byte ? ST_OK : res_status;
        res.used_slots = used;
        res.free_slots = r_slots - used;
        res.is_full    = n_full;
        res.is_empty   = !n_full && (n_head == n_tail);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots     <= SLOTS_RESET;
            r_bytes     <= BYTES_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_full      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_slots <= n_slots;
            r_bytes <= n_bytes;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_full  <= n_full;
            r_cnt   <= n_cnt;
            if (load_simple || load_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_src <= r_tail;
        end
        if (rd_en) begin
            r_pos <= rd_pos;
        end
        if (load_simple || load_byte) begin
            r_result <= res;
        end
    end

    assign o_stat.out_valid   = r_out_valid;
    assign o_stat.starts_read = ((t_op'(i_op) == OP_POP) || (t_op'(i_op) == OP_PEEK))
                                && !fifo_empty;
    assign o_stat.last_pos    = last_pos;
    assign o_out_valid        = r_out_valid;
    assign o_result           = r_result;

endmodule

// ===== sv/frcf_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the fixed-record circular FIFO: accepts operation words
// and sequences the byte stream of pop and peek. Uses frcf_pkg.
module frcf_ctrl import frcf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   out_free;

    // Output register frees up this cycle or is already empty
    assign out_free = !i_stat.out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = out_free;
                if (i_in_valid && out_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_stat.starts_read) begin
                        n_state = S_STREAM;
                    end
                end
            end
            S_STREAM: begin
                if (out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    if (i_stat.last_pos) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/frcf_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the fixed-record circular FIFO testbench: a ring predictor
// and the queue of result words it owes. Depends on frcf_pkg only.
package frcf_tb_pkg;
    import frcf_pkg::*;

    // Op codes outside the defined set, and register indexes with no register
    localparam logic [OP_W-1:0]      OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0]      OP_RSVD_LAST  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B  = 2'd3;

    class ring_scoreboard;
        logic [BYTE_W-1:0] store_img [STORE_DEPTH];
        logic [SLOT_W-1:0] wr_slot;
        logic [SLOT_W-1:0] rd_slot;
        logic              ring_full;
        logic [RB_W-1:0]   build_pos;
        logic [SCNT_W-1:0] slots_cfg;
        logic [RB_W-1:0]   bytes_cfg;
        t_result           results_due[$];
        int unsigned       mismatches;

        function new();
            foreach (store_img[i]) store_img[i] = '0;
            slots_cfg  = SLOTS_RESET;
            bytes_cfg  = BYTES_RESET;
            mismatches = 0;
            restart();
        endfunction

        // Empty the ring and drop any record under construction
        function void restart();
            wr_slot   = '0;
            rd_slot   = '0;
            ring_full = 1'b0;
            build_pos = '0;
        endfunction

        // Register values clamp into their legal ranges
        function int unsigned slot_count();
            if (slots_cfg == 0) return 1;
            if (slots_cfg > MAX_SLOTS) return MAX_SLOTS;
            return slots_cfg;
        endfunction

        function int unsigned byte_count();
            if (bytes_cfg == 0) return 1;
            if (bytes_cfg > MAX_RECORD_BYTES) return MAX_RECORD_BYTES;
            return bytes_cfg;
        endfunction

        function logic [SLOT_W-1:0] step_slot(logic [SLOT_W-1:0] s);
            int unsigned n;
            n = int'(s) + 1;
            if (n >= slot_count()) return '0;
            return SLOT_W'(n);
        endfunction

        function int unsigned held_records();
            if (ring_full) return slot_count();
            if (wr_slot >= rd_slot) return int'(wr_slot) - int'(rd_slot);
            return slot_count() - (int'(rd_slot) - int'(wr_slot));
        endfunction

        function bit ring_empty();
            return !ring_full && wr_slot == rd_slot;
        endfunction

        function int unsigned byte_addr(logic [SLOT_W-1:0] slot, int unsigned pos);
            return (int'(slot) * byte_count() + pos) % STORE_DEPTH;
        endfunction

        function int unsigned pending();
            return results_due.size();
        endfunction

        // Queue one result word carrying the ring counts as they stand now
        function void queue_result(logic [BYTE_W-1:0] b, logic last, t_status st);
            t_result r;
            int unsigned used;
            used         = held_records();
            r.out_byte   = b;
            r.last_byte  = last;
            r.status     = st;
            r.used_slots = SCNT_W'(used);
            r.free_slots = SCNT_W'(slot_count() - used);
            r.is_full    = ring_full;
            r.is_empty   = ring_empty();
            results_due.push_back(r);
        endfunction

        // Register write: unknown indexes are dropped, known ones flush the ring
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SLOTS_IN_USE: begin
                    slots_cfg = data[SCNT_W-1:0];
                    restart();
                end
                CFG_RECORD_BYTES: begin
                    bytes_cfg = data[RB_W-1:0];
                    restart();
                end
                default: ;
            endcase
        endfunction

        // Advance the ring by one accepted operation word
        function void predict(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data);
            int unsigned nb;
            logic [SLOT_W-1:0] src;
            nb = byte_count();
            case (op) inside
                OP_PUSH: begin
                    if (ring_full) begin
                        queue_result('0, 1'b1, ST_FULL);
                        return;
                    end
                    if (build_pos >= nb) build_pos = '0;
                    store_img[byte_addr(wr_slot, build_pos)] = data;
                    build_pos = build_pos + 1'b1;
                    // commit the record once its last byte is in
                    if (build_pos >= nb) begin
                        build_pos = '0;
                        wr_slot   = step_slot(wr_slot);
                        if (wr_slot == rd_slot) ring_full = 1'b1;
                    end
                    queue_result('0, 1'b1, ST_OK);
                end
                OP_POP, OP_PEEK: begin
                    if (ring_empty()) begin
                        queue_result('0, 1'b1, ST_EMPTY);
                        return;
                    end
                    src = rd_slot;
                    if (op == OP_POP) begin
                        rd_slot   = step_slot(rd_slot);
                        ring_full = 1'b0;
                    end
                    for (int i = 0; i < nb; i++)
                        queue_result(store_img[byte_addr(src, i)], i + 1 == nb, ST_OK);
                end
                OP_DROP: begin
                    if (ring_empty()) begin
                        queue_result('0, 1'b1, ST_EMPTY);
                        return;
                    end
                    rd_slot   = step_slot(rd_slot);
                    ring_full = 1'b0;
                    queue_result('0, 1'b1, ST_OK);
                end
                OP_FLUSH: begin
                    restart();
                    queue_result('0, 1'b1, ST_OK);
                end
                default: queue_result('0, 1'b1, ST_OK);
            endcase
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        // Match one accepted result word against the oldest one owed
        function void check_result(t_result got);
            t_result want;
            if (results_due.size() == 0) begin
                $error("result word with none owed: out_byte %0d status %0d",
                       got.out_byte, got.status);
                mismatches++;
                return;
            end
            want = results_due.pop_front();
            compare_field("out_byte",   want.out_byte,   got.out_byte);
            compare_field("last_byte",  want.last_byte,  got.last_byte);
            compare_field("status",     want.status,     got.status);
            compare_field("used_slots", want.used_slots, got.used_slots);
            compare_field("free_slots", want.free_slots, got.free_slots);
            compare_field("is_full",    want.is_full,    got.is_full);
            compare_field("is_empty",   want.is_empty,   got.is_empty);
        endfunction

        // Anything still owed at the end is a failure
        function void settle();
            if (results_due.size() != 0) begin
                $error("%0d result words never arrived", results_due.size());
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ===== tb/tb_fixed_record_circular_fifo.sv =====
`timescale 1ns / 1ps
// Testbench for fixed_record_circular_fifo: directed corner cases, then random
// record traffic over many ring layouts. Uses frcf_pkg, frcf_ifs, frcf_tb_pkg.
module tb_fixed_record_circular_fifo import frcf_pkg::*, frcf_tb_pkg::*; ;

    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 7;
    localparam int          IDLE_PCT      = 20;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          RANDOM_WORDS  = 400;
    localparam int          SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 300000;

    logic i_clk;
    logic i_rst_n;

    frcf_in_if  in_ch();
    frcf_out_if out_ch();
    frcf_cfg_if cfg_ch();

    ring_scoreboard sb;
    bit             steady;
    bit             hold_req;
    bit             word_taken;
    bit             cfg_taken;
    int unsigned    words_sent;
    int unsigned    cycle_count;

    fixed_record_circular_fifo DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Sample every handshake at the rising edge: results first, then new words
    always @(posedge i_clk) begin : watch
        t_result got;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.out_byte   = out_ch.out_byte;
                got.last_byte  = out_ch.last_byte;
                got.status     = out_ch.status;
                got.used_slots = out_ch.used_slots;
                got.free_slots = out_ch.free_slots;
                got.is_full    = out_ch.is_full;
                got.is_empty   = out_ch.is_empty;
                sb.check_result(got);
            end
            if (in_ch.valid && in_ch.ready) begin
                sb.predict(in_ch.op, in_ch.data_byte);
                word_taken = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.write_reg(cfg_ch.index, cfg_ch.data);
                cfg_taken = 1'b1;
            end
        end
    end

    // Result side: random stalls, or a long hold-off when asked
    initial begin : result_sink
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_fixed_record_circular_fifo: done, errors");
        $finish;
    end

    // Offer one operation word and hold it until it is taken
    task automatic send_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                in_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.data_byte <= data;
        do @(negedge i_clk); while (!word_taken);
        word_taken = 1'b0;
        if (op <= OP_FLUSH) words_sent++;
    endtask

    task automatic push_bytes(input int unsigned n);
        for (int k = 0; k < n; k++) send_word(OP_PUSH, 8'($urandom));
    endtask

    // Stop offering and wait until every owed result word has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic issue_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(negedge i_clk); while (!cfg_taken);
        cfg_taken = 1'b0;
    endtask

    // Two back-to-back register writes on an idle block
    task automatic write_pair(input logic [CFG_IDX_W-1:0] idx_a,
                              input logic [CFG_DATA_W-1:0] data_a,
                              input logic [CFG_IDX_W-1:0] idx_b,
                              input logic [CFG_DATA_W-1:0] data_b);
        wait_drained();
        issue_cfg(idx_a, data_a);
        issue_cfg(idx_b, data_b);
        cfg_ch.valid <= 1'b0;
    endtask

    // One layout: mostly whole records, swinging between filling and draining
    task automatic run_phase(input logic [CFG_DATA_W-1:0] slots_raw,
                             input logic [CFG_DATA_W-1:0] bytes_raw,
                             input int unsigned budget, input bit hold_off);
        int unsigned nb;
        int unsigned stop_at;
        int unsigned roll;
        bit filling;
        write_pair(CFG_SLOTS_IN_USE, slots_raw, CFG_RECORD_BYTES, bytes_raw);
        if (hold_off) hold_req = 1'b1;
        nb      = sb.byte_count();
        stop_at = words_sent + budget;
        filling = 1'b1;
        while (words_sent < stop_at) begin
            if (sb.held_records() == 0) filling = 1'b1;
            else if (sb.ring_full && $urandom_range(0, 2) == 0) filling = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < (filling ? 70 : 15))
                push_bytes(nb);
            else if (roll < (filling ? 78 : 45))
                send_word(OP_PEEK, 8'($urandom));
            else if (roll < (filling ? 86 : 75))
                send_word(OP_POP, 8'($urandom));
            else if (roll < 90)
                send_word(OP_DROP, 8'($urandom));
            else if (roll < 94)
                push_bytes($urandom_range(1, nb));
            else if (roll < 96)
                send_word(OP_FLUSH, 8'($urandom));
            else if (roll < 98)
                send_word(OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST)),
                          8'($urandom));
            else
                wait_drained();
        end
    endtask

    initial begin : stimulus
        int unsigned target;
        int unsigned phase_no;
        int unsigned roll;
        logic [CFG_DATA_W-1:0] slots_raw;
        logic [CFG_DATA_W-1:0] bytes_raw;

        sb               = new();
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.op         = OP_PUSH;
        in_ch.data_byte  = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_SLOTS_IN_USE;
        cfg_ch.data      = '0;
        steady           = 1'b0;
        hold_req         = 1'b0;
        word_taken       = 1'b0;
        cfg_taken        = 1'b0;
        words_sent       = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty-ring rejects at the reset layout of 16 slots by 4 bytes
        send_word(OP_PEEK, 8'h00);
        send_word(OP_POP,  8'hFF);
        send_word(OP_DROP, 8'h00);
        // One full record with byte extremes, read back twice
        send_word(OP_PUSH, 8'h00);
        send_word(OP_PUSH, 8'hFF);
        send_word(OP_PUSH, 8'h5A);
        send_word(OP_PUSH, 8'hA5);
        send_word(OP_PEEK, 8'h00);
        send_word(OP_POP,  8'h00);
        send_word(OP_RSVD_FIRST, 8'h3C);
        send_word(OP_RSVD_LAST,  8'hC3);
        // Flush discards a half-built record
        send_word(OP_PUSH, 8'h12);
        send_word(OP_PUSH, 8'h34);
        send_word(OP_FLUSH, 8'h00);
        send_word(OP_PEEK, 8'h00);

        // Zero in both registers clamps to one slot of one byte
        write_pair(CFG_SLOTS_IN_USE, 7'd0, CFG_RECORD_BYTES, 7'd0);
        send_word(OP_PUSH, 8'h80);
        send_word(OP_PUSH, 8'h01);
        send_word(OP_PEEK, 8'h00);
        send_word(OP_DROP, 8'h00);
        send_word(OP_DROP, 8'h00);
        send_word(OP_PUSH, 8'h7F);
        // Writes to unused indexes must leave the full ring intact
        write_pair(CFG_UNUSED_A, 7'h7F, CFG_UNUSED_B, 7'h00);
        send_word(OP_POP, 8'h00);

        // Fixed layouts: masked slot count with longest records, a long
        // receiver hold-off on a small-record ring, an unthrottled stretch
        target = words_sent + RANDOM_WORDS;
        run_phase(7'd65, 7'd65, 150, 1'b0);
        run_phase(7'd16, 7'd1, 60, 1'b1);
        steady = 1'b1;
        run_phase(7'd17, 7'd2, 50, 1'b0);
        steady = 1'b0;

        // Random layouts, mostly small so the ring fills and wraps often
        phase_no = 0;
        while (words_sent < target) begin
            roll = $urandom_range(0, 9);
            if (roll < 6)      slots_raw = CFG_DATA_W'($urandom_range(1, 6));
            else if (roll < 9) slots_raw = CFG_DATA_W'($urandom_range(7, 16));
            else               slots_raw = CFG_DATA_W'($urandom_range(0, 127));
            roll = $urandom_range(0, 9);
            if (roll < 7)      bytes_raw = CFG_DATA_W'($urandom_range(1, 6));
            else if (roll < 9) bytes_raw = CFG_DATA_W'($urandom_range(7, 12));
            else               bytes_raw = CFG_DATA_W'($urandom_range(0, 127));
            steady = (phase_no % 5 == 4);
            run_phase(slots_raw, bytes_raw, 40, 1'b0);
            phase_no++;
        end
        steady = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.settle();
        if (sb.mismatches == 0)
            $display("tb_fixed_record_circular_fifo: done, clean");
        else
            $display("tb_fixed_record_circular_fifo: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
sv/frcf_pkg.sv
sv/frcf_ifs.sv
sv/frcf_ram.sv
sv/frcf_datapath.sv
sv/frcf_ctrl.sv
sv/fixed_record_circular_fifo.sv
tb/frcf_tb_pkg.sv
tb/tb_fixed_record_circular_fifo.sv
